@@ rtl/pcpb_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpb_pkg
// Shared types and constants of the projected bounding box unit.
// ----------------------------------------------------------------------------
package pcpb_pkg;

  // field and state widths
  localparam int PROJ_W   = 24;
  localparam int FOCAL_W  = 12;
  localparam int DIM_W    = 13;
  localparam int MARGIN_W = 8;
  localparam int Z_W      = 15;
  localparam int PIX_W    = 12;
  localparam int OUT_W    = 56;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // parameter defaults
  localparam int DEF_PIXEL_FRAC_BITS = 4;
  localparam int DEF_COORD_WIDTH     = 16;
  localparam int QUEUE_DEPTH         = 2;

  // register reset values
  localparam logic [FOCAL_W-1:0]  FOCAL_RST  = 12'd525;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd5;
  localparam logic [PIX_W-1:0]    PIX_MAX    = 12'd4095;

  // register map
  typedef enum logic [1:0] {
    REG_FOCAL  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_MARGIN = 2'd3
  } reg_idx_e;

  // one projected point handed from front to back
  typedef struct packed {
    logic signed [PROJ_W-1:0] col;
    logic signed [PROJ_W-1:0] row;
    logic                     sat;
    logic                     last;
  } proj_t;

  // one box, lowest field in the lowest bits
  typedef struct packed {
    logic             sat;
    logic [PIX_W-1:0] bottom;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] left;
  } box_t;

endpackage

@@ rtl/pcpb_front.sv @@
// ----------------------------------------------------------------------------
// pcpb_front
// Takes a point, scales by focal length and divides by depth (one quotient
// bit a cycle per axis), adds the image centre and saturates.
// ----------------------------------------------------------------------------
module pcpb_front import pcpb_pkg::*; #(
  parameter int PIXEL_FRAC_BITS = DEF_PIXEL_FRAC_BITS,
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] x_i,
  input  logic [COORD_WIDTH-1:0] y_i,
  input  logic [Z_W-1:0]         z_i,
  input  logic                   last_i,
  input  logic [FOCAL_W-1:0]     focal_i,
  input  logic [DIM_W-1:0]       width_i,
  input  logic [DIM_W-1:0]       height_i,
  input  logic                   full_i,
  output logic                   push_o,
  output proj_t                  entry_o
);

  localparam int NUM_W = FOCAL_W + COORD_WIDTH + PIXEL_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int Q_W   = NUM_W + 1;
  localparam int CTR_W = DIM_W + PIXEL_FRAC_BITS + 1;
  localparam int S_W   = (NUM_W + 2 > PROJ_W + 1) ? NUM_W + 2 : PROJ_W + 1;
  localparam int PRD_W = FOCAL_W + COORD_WIDTH;
  localparam logic [CTR_W-1:0] HALF = CTR_W'((1 << PIXEL_FRAC_BITS) >> 1);
  localparam logic signed [S_W-1:0] SMAX = S_W'((1 << (PROJ_W - 1)) - 1);
  localparam logic signed [S_W-1:0] SMIN = -S_W'(1 << (PROJ_W - 1));
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_W - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_PUSH} state_e;

  state_e                   state_q;
  logic [COORD_WIDTH-1:0]   x_q, y_q;
  logic [Z_W-1:0]           z_q;
  logic                     last_q, negx_q, negy_q;
  logic [NUM_W-1:0]         numx_q, numy_q;
  logic [Z_W-1:0]           remx_q, remy_q;
  logic [CNT_W-1:0]         cnt_q;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [Z_W:0] div_step(logic [Z_W-1:0] rem, logic b,
                                            logic [Z_W-1:0] d);
    logic [Z_W:0] sh;
    logic [Z_W:0] df;
    logic         ge;
    sh = {rem, b};
    df = sh - {1'b0, d};
    ge = sh >= {1'b0, d};
    return ge ? {1'b1, df[Z_W-1:0]} : {1'b0, sh[Z_W-1:0]};
  endfunction

  // signed quotient plus centre, saturated: {flag, value}
  function automatic logic [PROJ_W:0] finish(logic [NUM_W-1:0] mag, logic neg,
                                             logic [CTR_W-1:0] ctr);
    logic signed [Q_W-1:0] q;
    logic signed [S_W-1:0] s;
    q = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    s = S_W'(q) + S_W'($signed(ctr));
    if (s > SMAX) return {1'b1, SMAX[PROJ_W-1:0]};
    else if (s < SMIN) return {1'b1, SMIN[PROJ_W-1:0]};
    else return {1'b0, s[PROJ_W-1:0]};
  endfunction

  // magnitudes and products
  logic [COORD_WIDTH-1:0] magx, magy;
  logic [PRD_W-1:0]       prodx, prody;
  assign magx  = x_q[COORD_WIDTH-1] ? (~x_q + 1'b1) : x_q;
  assign magy  = y_q[COORD_WIDTH-1] ? (~y_q + 1'b1) : y_q;
  assign prodx = focal_i * magx;
  assign prody = focal_i * magy;

  // divider steps
  logic [Z_W:0] stepx, stepy;
  assign stepx = div_step(remx_q, numx_q[NUM_W-1], z_q);
  assign stepy = div_step(remy_q, numy_q[NUM_W-1], z_q);

  // centres and final sums
  logic [CTR_W-1:0] ctrx, ctry;
  logic [PROJ_W:0]  finx, finy;
  assign ctrx = (CTR_W'(width_i >> 1) << PIXEL_FRAC_BITS) - HALF;
  assign ctry = (CTR_W'(height_i >> 1) << PIXEL_FRAC_BITS) - HALF;
  assign finx = finish(numx_q, negx_q, ctrx);
  assign finy = finish(numy_q, negy_q, ctry);

  assign in_ready_o    = (state_q == ST_IDLE);
  assign push_o        = (state_q == ST_PUSH) && !full_i;
  assign entry_o.col   = finx[PROJ_W-1:0];
  assign entry_o.row   = finy[PROJ_W-1:0];
  assign entry_o.sat   = finx[PROJ_W] | finy[PROJ_W];
  assign entry_o.last  = last_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_CNT) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= (z_i == '0) ? Z_W'(1) : z_i;
      last_q <= last_i;
    end
    if (state_q == ST_MUL) begin
      numx_q <= NUM_W'(prodx) << PIXEL_FRAC_BITS;
      numy_q <= NUM_W'(prody) << PIXEL_FRAC_BITS;
      negx_q <= x_q[COORD_WIDTH-1];
      negy_q <= y_q[COORD_WIDTH-1];
      remx_q <= '0;
      remy_q <= '0;
    end
    if (state_q == ST_DIV) begin
      numx_q <= {numx_q[NUM_W-2:0], stepx[Z_W]};
      numy_q <= {numy_q[NUM_W-2:0], stepy[Z_W]};
      remx_q <= stepx[Z_W-1:0];
      remy_q <= stepy[Z_W-1:0];
    end
  end

endmodule

@@ rtl/pcpb_queue.sv @@
// ----------------------------------------------------------------------------
// pcpb_queue
// Small request queue between the projection front and the extent back.
// ----------------------------------------------------------------------------
module pcpb_queue import pcpb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  proj_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output proj_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  proj_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/pcpb_back.sv @@
// ----------------------------------------------------------------------------
// pcpb_back
// Running min/max of the projected points and box output on the last point.
// ----------------------------------------------------------------------------
module pcpb_back import pcpb_pkg::*; #(
  parameter int PIXEL_FRAC_BITS = DEF_PIXEL_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  proj_t               entry_i,
  output logic                pop_o,
  input  logic [MARGIN_W-1:0] margin_i,
  input  logic [DIM_W-1:0]    width_i,
  input  logic [DIM_W-1:0]    height_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output box_t                box_o
);

  localparam int E_W = PROJ_W + 1;

  logic signed [PROJ_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
  logic signed [PROJ_W-1:0] min_col_d, max_col_d, min_row_d, max_row_d;
  logic                     start_q, sat_q, sat_d;
  logic                     out_valid_q;
  box_t                     box_q;

  // edge to pixel with clamp to the image
  function automatic logic [PIX_W-1:0] to_pixel(logic signed [E_W-1:0] v,
                                                logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] lim;
    logic [E_W-1:0]   p;
    lim = (dim == '0) ? '0 : dim - 1'b1;
    if (lim > DIM_W'(PIX_MAX)) lim = DIM_W'(PIX_MAX);
    p = E_W'(v >>> PIXEL_FRAC_BITS);
    if (v < 0) return '0;
    else if (p > E_W'(lim)) return lim[PIX_W-1:0];
    else return p[PIX_W-1:0];
  endfunction

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign box_o       = box_q;

  // extent update
  always_comb begin
    if (start_q) begin
      min_col_d = entry_i.col;
      max_col_d = entry_i.col;
      min_row_d = entry_i.row;
      max_row_d = entry_i.row;
      sat_d     = entry_i.sat;
    end else begin
      min_col_d = (entry_i.col < min_col_q) ? entry_i.col : min_col_q;
      max_col_d = (entry_i.col > max_col_q) ? entry_i.col : max_col_q;
      min_row_d = (entry_i.row < min_row_q) ? entry_i.row : min_row_q;
      max_row_d = (entry_i.row > max_row_q) ? entry_i.row : max_row_q;
      sat_d     = sat_q | entry_i.sat;
    end
  end

  // padded edges
  logic signed [E_W-1:0] pad, left_e, top_e, right_e, bottom_e;
  assign pad      = $signed(E_W'(margin_i) << PIXEL_FRAC_BITS);
  assign left_e   = E_W'(min_col_d) - pad;
  assign top_e    = E_W'(min_row_d) - pad;
  assign right_e  = E_W'(max_col_d) + pad;
  assign bottom_e = E_W'(max_row_d) + pad;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b1;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      min_col_q   <= '0;
      max_col_q   <= '0;
      min_row_q   <= '0;
      max_row_q   <= '0;
    end else begin
      if (pop_o && entry_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        min_col_q <= min_col_d;
        max_col_q <= max_col_d;
        min_row_q <= min_row_d;
        max_row_q <= max_row_d;
        sat_q     <= sat_d;
        start_q   <= entry_i.last;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.last) begin
      box_q.left   <= to_pixel(left_e, width_i);
      box_q.top    <= to_pixel(top_e, height_i);
      box_q.right  <= to_pixel(right_e, width_i);
      box_q.bottom <= to_pixel(bottom_e, height_i);
      box_q.sat    <= sat_d;
    end
  end

endmodule

@@ rtl/point_cluster_projected_bbox_unit.sv @@
// ----------------------------------------------------------------------------
// point_cluster_projected_bbox_unit
// Pinhole projection of cluster points with a padded, clamped bounding box.
// ----------------------------------------------------------------------------
// flow: an accepted point is scaled by the focal length, divided by depth
// one quotient bit a cycle, then pushed into the queue, stalling while the
// queue is full; the box is valid the cycle after the last point leaves the queue
// accept: a new point is taken only once the previous one has been pushed
// reset: registers take their defaults, the next point opens a new cluster
module point_cluster_projected_bbox_unit import pcpb_pkg::*; #(
  parameter int PIXEL_FRAC_BITS = DEF_PIXEL_FRAC_BITS,
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
  parameter int IN_W            = ((2 * COORD_WIDTH + Z_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,  // point_x, point_y, point_z
  input  logic              s_axis_tlast,  // last_point
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,  // box_left, box_top, box_right,
                                           // box_bottom, saturated
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [FOCAL_W-1:0]  focal_q;
  logic [DIM_W-1:0]    width_q, height_q;
  logic [MARGIN_W-1:0] margin_q;
  reg_idx_e            idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= FOCAL_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      margin_q <= MARGIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FOCAL:  focal_q  <= pwdata[FOCAL_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_FOCAL:  prdata = CFG_DW'(focal_q);
      REG_WIDTH:  prdata = CFG_DW'(width_q);
      REG_HEIGHT: prdata = CFG_DW'(height_q);
      REG_MARGIN: prdata = CFG_DW'(margin_q);
      default:    prdata = '0;
    endcase
  end

  // front, queue, back
  logic  push, q_full, q_valid, pop;
  proj_t f_entry, q_entry;
  box_t  box;

  pcpb_front #(
    .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .x_i       (s_axis_tdata[COORD_WIDTH-1:0]),
    .y_i       (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .z_i       (s_axis_tdata[2*COORD_WIDTH+Z_W-1:2*COORD_WIDTH]),
    .last_i    (s_axis_tlast),
    .focal_i   (focal_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .full_i    (q_full),
    .push_o    (push),
    .entry_o   (f_entry)
  );

  pcpb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (f_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_entry)
  );

  pcpb_back #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .valid_i    (q_valid),
    .entry_i    (q_entry),
    .pop_o      (pop),
    .margin_i   (margin_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .box_o      (box)
  );

  assign m_axis_tdata = OUT_W'(box);

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full)) else $error("push into full queue");

  a_one_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second point taken while projecting");

  a_box_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop && q_entry.last))
    else $error("box without a last point");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Streams clusters of points into the projected bounding box unit under random
// gaps and back-pressure, predicts each box and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
  import pcpb_pkg::*;

  localparam int FB  = DEF_PIXEL_FRAC_BITS;
  localparam int CW  = DEF_COORD_WIDTH;
  localparam int IW  = ((2 * CW + Z_W + 7) / 8) * 8;
  localparam int LAT = 12 + CW + FB + 3;
  localparam longint P_MAX = 64'sd8388607;
  localparam longint P_MIN = -64'sd8388608;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [Z_W-1:0]       z;
    logic                 last;
    logic                 known;
    box_t                 box;
  } point_row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tlast = 1'b0, m_axis_tready = 1'b0;
  logic [IW-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, pready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0, prdata;

  point_cluster_projected_bbox_unit uut (.*);

  // predictor state
  logic [FOCAL_W-1:0]  focal = FOCAL_RST;
  logic [DIM_W-1:0]    img_w = WIDTH_RST, img_h = HEIGHT_RST;
  logic [MARGIN_W-1:0] margin = MARGIN_RST;
  longint min_c, max_c, min_r, max_r;
  bit first_pt = 1, sat_acc = 0;

  box_t box_q[$];
  int errors = 0, boxes_seen = 0, points_sent = 0, phase_no = 0;
  bit drain = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint centre(logic [DIM_W-1:0] d);
    return longint'(d / 2) * (64'sd1 << FB) - ((FB > 0) ? (64'sd1 << (FB - 1)) : 0);
  endfunction

  function automatic longint proj_coord(longint c, logic [Z_W-1:0] z, longint ctr);
    longint q, s;
    q = (longint'(focal) * c * (64'sd1 << FB)) / longint'(z == 0 ? 1 : z);
    s = q + ctr;
    if (s > P_MAX) begin
      sat_acc = 1; s = P_MAX;
    end else if (s < P_MIN) begin
      sat_acc = 1; s = P_MIN;
    end
    return s;
  endfunction

  function automatic logic [PIX_W-1:0] edge_pixel(longint v, logic [DIM_W-1:0] d);
    longint lim, p;
    lim = (d == 0) ? 0 : longint'(d) - 1;
    if (lim > 4095) lim = 4095;
    if (v < 0) return '0;
    p = v >>> FB;
    return (p > lim) ? lim[PIX_W-1:0] : p[PIX_W-1:0];
  endfunction

  // project one point and return a box when it closes the cluster
  function automatic bit predict_box(point_row_t pt, output box_t b);
    longint pc, pr, pad;
    if (first_pt) sat_acc = 0;
    pc = proj_coord(longint'(pt.x), pt.z, centre(img_w));
    pr = proj_coord(longint'(pt.y), pt.z, centre(img_h));
    if (first_pt) begin
      min_c = pc; max_c = pc; min_r = pr; max_r = pr; first_pt = 0;
    end else begin
      if (pc < min_c) min_c = pc;
      if (pc > max_c) max_c = pc;
      if (pr < min_r) min_r = pr;
      if (pr > max_r) max_r = pr;
    end
    if (!pt.last) return 0;
    pad = longint'(margin) * (64'sd1 << FB);
    b.left   = edge_pixel(min_c - pad, img_w);
    b.top    = edge_pixel(min_r - pad, img_h);
    b.right  = edge_pixel(max_c + pad, img_w);
    b.bottom = edge_pixel(max_r + pad, img_h);
    b.sat    = sat_acc;
    first_pt = 1;
    return 1;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = CFG_AW'(idx) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_FOCAL:  focal  = val[FOCAL_W-1:0];
      REG_WIDTH:  img_w  = val[DIM_W-1:0];
      REG_HEIGHT: img_h  = val[DIM_W-1:0];
      REG_MARGIN: margin = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_point(point_row_t pt);
    box_t b;
    repeat ($urandom_range(0, 14)) @(negedge clk_i);
    s_axis_tdata  = {{(IW - 2 * CW - Z_W){1'b0}}, pt.z, pt.y, pt.x};
    s_axis_tlast  = pt.last;
    s_axis_tvalid = 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_box(pt, b)) begin
      if (pt.known && b != pt.box) begin
        $error("directed box: expected %h actual prediction %h", pt.box, b);
        errors++;
      end
      box_q.push_back(b);
    end
    points_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (box_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i); guard++;
    end
    repeat (2 * LAT + 4) @(posedge clk_i);
  endtask

  // box checker and random back-pressure
  initial begin
    box_t got, exp_b;
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--; m_axis_tready = 0;
      end else begin
        m_axis_tready = 1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(box_t)-1:0];
        boxes_seen++;
        if (box_q.size() == 0) begin
          $error("box with none expected: %h", got);
          errors++;
        end else begin
          exp_b = box_q.pop_front();
          if (got.left != exp_b.left) begin
            $error("box_left expected %0d actual %0d", exp_b.left, got.left); errors++;
          end
          if (got.top != exp_b.top) begin
            $error("box_top expected %0d actual %0d", exp_b.top, got.top); errors++;
          end
          if (got.right != exp_b.right) begin
            $error("box_right expected %0d actual %0d", exp_b.right, got.right); errors++;
          end
          if (got.bottom != exp_b.bottom) begin
            $error("box_bottom expected %0d actual %0d", exp_b.bottom, got.bottom);
            errors++;
          end
          if (got.sat != exp_b.sat) begin
            $error("saturated expected %0b actual %0b", exp_b.sat, got.sat); errors++;
          end
        end
        if (!drain && $urandom_range(0, 2) != 0) hold = $urandom_range(0, 14);
      end
    end
  end

  function automatic point_row_t mk(int x, int y, int z, bit l, bit k = 0,
                                    int bl = 0, int bt = 0, int br = 0, int bb = 0,
                                    bit bs = 0);
    point_row_t p;
    p.x = CW'(x); p.y = CW'(y); p.z = Z_W'(z); p.last = l; p.known = k;
    p.box = '{sat: bs, bottom: PIX_W'(bb), right: PIX_W'(br), top: PIX_W'(bt),
              left: PIX_W'(bl)};
    return p;
  endfunction

  function automatic point_row_t rand_point(bit l);
    point_row_t p;
    p.known = 0; p.last = l;
    case ($urandom_range(0, 3))
      0: begin
        p.x = CW'($urandom); p.y = CW'($urandom); p.z = Z_W'($urandom_range(0, 32767));
      end
      1: begin
        p.x = CW'($urandom_range(0, 4000) - 2000);
        p.y = CW'($urandom_range(0, 4000) - 2000);
        p.z = Z_W'($urandom_range(1000, 32767));
      end
      2: begin
        p.x = CW'($urandom); p.y = CW'($urandom); p.z = Z_W'($urandom_range(0, 3));
      end
      default: begin
        p.x = CW'($urandom_range(0, 600) - 300);
        p.y = CW'($urandom_range(0, 600) - 300);
        p.z = Z_W'($urandom_range(200, 4000));
      end
    endcase
    return p;
  endfunction

  task automatic random_phase(int n);
    int len;
    while (n > 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_point(rand_point(i == len - 1));
      n -= len;
    end
  endtask

  point_row_t dir_rows[$];

  initial begin
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed rows: centre point, extremes, zero depth, saturation
    dir_rows = '{
      mk(0, 0, 100, 1, 1, 314, 234, 324, 244, 0),
      mk(32767, 32767, 1, 1, 1, 639, 479, 639, 479, 1),
      mk(-32768, -32768, 1, 1, 1, 0, 0, 0, 0, 1),
      mk(-32768, 32767, 0, 1),
      mk(100, -100, 32767, 0), mk(-100, 100, 32767, 1),
      mk(10, 20, 500, 0), mk(-30, 5, 700, 0), mk(0, -40, 900, 1),
      mk(32767, 0, 1, 0), mk(0, 0, 100, 1),
      mk(0, 0, 16384, 0), mk(-21846, 21845, 27306, 1)
    };
    foreach (dir_rows[i]) send_point(dir_rows[i]);
    wait_idle();

    // settings across the register ranges, extremes included
    for (phase_no = 0; phase_no < 8; phase_no++) begin
      case (phase_no)
        0: begin
          write_reg(REG_FOCAL, 1); write_reg(REG_WIDTH, 2);
          write_reg(REG_HEIGHT, 2); write_reg(REG_MARGIN, 0);
        end
        1: begin
          write_reg(REG_FOCAL, 4095); write_reg(REG_WIDTH, 4096);
          write_reg(REG_HEIGHT, 4096); write_reg(REG_MARGIN, 255);
        end
        2: begin
          write_reg(REG_FOCAL, 580); write_reg(REG_WIDTH, 640);
          write_reg(REG_HEIGHT, 480); write_reg(REG_MARGIN, 5);
        end
        3: begin
          write_reg(REG_FOCAL, 32'hFFFF_F000 | 32'd7); write_reg(REG_WIDTH, 8191);
          write_reg(REG_HEIGHT, 0); write_reg(REG_MARGIN, 128);
        end
        default: begin
          write_reg(REG_FOCAL, $urandom_range(1, 4095));
          write_reg(REG_WIDTH, $urandom_range(2, 4096));
          write_reg(REG_HEIGHT, $urandom_range(2, 4096));
          write_reg(REG_MARGIN, $urandom_range(0, 255));
        end
      endcase
      random_phase(75);
      wait_idle();
    end

    drain = 1;
    wait_idle();
    $display("run: %0d points, %0d boxes checked over %0d register settings",
             points_sent, boxes_seen, phase_no + 1);
    if (errors == 0 && box_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (box_q.size() != 0) $error("%0d boxes never arrived", box_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcpb_pkg.sv
rtl/pcpb_front.sv
rtl/pcpb_queue.sv
rtl/pcpb_back.sv
rtl/point_cluster_projected_bbox_unit.sv
dv/tb.sv
